// File: sv/multi_tap_echo_adder_defines.svh
// ----------------------------------------------------------------------------
// Multi-tap echo adder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MULTI_TAP_ECHO_ADDER_DEFINES_SVH
`define MULTI_TAP_ECHO_ADDER_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define MTEA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define MTEA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mtea_pkg.sv
// ----------------------------------------------------------------------------
// Multi-tap echo adder package
// Sizes, types and helper functions shared by the echo adder modules.
// ----------------------------------------------------------------------------
package mtea_pkg;

  localparam int MAX_DELAY  = 65536;
  localparam int TAPS       = 4;
  localparam int HIST_DEPTH = TAPS * MAX_DELAY;

  localparam int SAMPLE_W = 16;
  localparam int ECHO_W   = 3;
  localparam int DELAY_W  = 17;
  localparam int CFG_W    = 17;
  localparam int INDEX_W  = 1;

  localparam int AW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int BW  = $clog2(HIST_DEPTH + 1);
  localparam int DW  = $clog2(MAX_DELAY + 1);
  localparam int CW  = $clog2(TAPS + 1);
  localparam int ECW = (ECHO_W > CW) ? ECHO_W : CW;

  localparam logic [INDEX_W-1:0] REG_ECHO_COUNT    = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_DELAY_SAMPLES = INDEX_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [AW-1:0]              hist_addr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_ACC
  } mtea_state_t;

  typedef struct packed {
    logic       we;
    hist_addr_t waddr;
    sample_t    wdata;
    logic       re;
    hist_addr_t raddr;
  } hist_req_t;

  function automatic logic [DW-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
    logic [DW+DELAY_W-1:0] wide;
    wide = (DW + DELAY_W)'(d);
    if (wide == '0) begin
      return DW'(1);
    end else if (wide > (DW + DELAY_W)'(MAX_DELAY)) begin
      return DW'(MAX_DELAY);
    end else begin
      return DW'(wide);
    end
  endfunction

  function automatic logic [CW-1:0] clamp_taps(input logic [ECHO_W-1:0] e);
    logic [ECW-1:0] wide;
    wide = ECW'(e);
    if (wide > ECW'(TAPS)) begin
      return CW'(TAPS);
    end else begin
      return CW'(wide);
    end
  endfunction

endpackage

// File: sv/mtea_hist_ram.sv
// ----------------------------------------------------------------------------
// Echo history memory
// Simple dual-port sample store with one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module mtea_hist_ram
  import mtea_pkg::*;
(
  input  logic      clk,
  input  hist_req_t req,
  output sample_t   rdata
);

  sample_t mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: sv/mtea_core.sv
// ----------------------------------------------------------------------------
// Echo adder sequencer
// Walks the taps of one sample through a shared address unit and adder.
// ----------------------------------------------------------------------------
`include "multi_tap_echo_adder_defines.svh"

module mtea_core
  import mtea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              sample_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sample_t              sample_out,
  input  logic [ECHO_W-1:0]    echo_count,
  input  logic [DELAY_W-1:0]   delay_samples,
  output hist_req_t            mem_req,
  input  sample_t              mem_rdata
);

  mtea_state_t state, state_next;

  sample_t    x, x_next;
  sample_t    acc, acc_next;
  hist_addr_t addr, addr_next;
  hist_addr_t pos, pos_next;
  logic [BW-1:0] back, back_next;
  logic [BW-1:0] fill, fill_next;
  logic [DW-1:0] dly, dly_next;
  logic [CW-1:0] remaining, remaining_next;
  logic          tap_ok, tap_ok_next;
  logic          out_valid_next;
  sample_t       sample_out_next;

  logic          accept;
  logic          out_free;
  logic          load;
  logic [AW:0]   addr_ext;
  logic [AW:0]   dly_ext;
  logic [AW:0]   addr_sub;
  hist_addr_t    tap_addr;
  logic [BW-1:0] tap_back;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // The history wraps, so a tap that reaches below slot zero folds back to the top.
  assign addr_ext = {1'b0, addr};
  assign dly_ext  = (AW + 1)'(dly);
  assign addr_sub = (addr_ext >= dly_ext) ? (addr_ext - dly_ext)
                                          : (addr_ext + (AW + 1)'(HIST_DEPTH) - dly_ext);
  assign tap_addr = addr_sub[AW-1:0];
  assign tap_back = back + BW'(dly);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    x          <= x_next;
    acc        <= acc_next;
    addr       <= addr_next;
    back       <= back_next;
    dly        <= dly_next;
    tap_ok     <= tap_ok_next;
    sample_out <= sample_out_next;
  end

  always_comb begin
    state_next      = state;
    x_next          = x;
    acc_next        = acc;
    addr_next       = addr;
    back_next       = back;
    dly_next        = dly;
    remaining_next  = remaining;
    tap_ok_next     = tap_ok;
    pos_next        = pos;
    fill_next       = fill;
    out_valid_next  = out_valid && out_stall;
    sample_out_next = sample_out;
    load            = 1'b0;
    mem_req.we      = 1'b0;
    mem_req.waddr   = pos;
    mem_req.wdata   = x;
    mem_req.re      = 1'b0;
    mem_req.raddr   = tap_addr;

    case (state)
      S_IDLE: begin
        if (accept) begin
          x_next         = sample_in;
          acc_next       = sample_in;
          addr_next      = pos;
          back_next      = '0;
          dly_next       = clamp_delay(delay_samples);
          remaining_next = clamp_taps(echo_count);
          state_next     = S_STEP;
        end
      end
      S_STEP: begin
        if (remaining != '0) begin
          mem_req.re     = 1'b1;
          addr_next      = tap_addr;
          back_next      = tap_back;
          tap_ok_next    = (tap_back <= fill);
          remaining_next = remaining - CW'(1);
          state_next     = S_ACC;
        end else if (out_free) begin
          load            = 1'b1;
          mem_req.we      = 1'b1;
          out_valid_next  = 1'b1;
          sample_out_next = acc;
          pos_next        = (pos == AW'(HIST_DEPTH - 1)) ? '0 : pos + AW'(1);
          fill_next       = (fill == BW'(HIST_DEPTH)) ? fill : fill + BW'(1);
          state_next      = S_IDLE;
        end
      end
      S_ACC: begin
        // Slots not yet written since reset read as silence.
        if (tap_ok) begin
          acc_next = acc + mem_rdata;
        end
        state_next = S_STEP;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `MTEA_ASSERT_ALWAYS(a_fill_bound, fill <= BW'(HIST_DEPTH), "fill count beyond history depth")
  `MTEA_ASSERT_SAME(a_load_free, load, !(out_valid && out_stall), "result overwrote a held result")
  `MTEA_ASSERT_NEXT(a_tap_limit, accept, remaining <= CW'(TAPS), "tap count above limit")

endmodule

// File: sv/multi_tap_echo_adder.sv
// ----------------------------------------------------------------------------
// Multi-tap echo adder
// Each of E taps (E the effective echo count) takes one S_STEP history read
// and one S_ACC add; no new request is taken until the result is registered.
// Reset clears the history by a fill count at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module multi_tap_echo_adder
  import mtea_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [INDEX_W-1:0] write_index,
  input  logic [CFG_W-1:0]   write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  sample_t            sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output sample_t            sample_out
);

  logic [ECHO_W-1:0]  echo_count;
  logic [DELAY_W-1:0] delay_samples;
  hist_req_t          mem_req;
  sample_t            mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_count    <= ECHO_W'(4);
      delay_samples <= DELAY_W'(44100);
    end else if (write_enable) begin
      case (write_index)
        REG_ECHO_COUNT:    echo_count    <= write_data[ECHO_W-1:0];
        REG_DELAY_SAMPLES: delay_samples <= write_data[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mtea_hist_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mtea_core u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_in     (sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .echo_count    (echo_count),
    .delay_samples (delay_samples),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

endmodule
